[rtl/assert_macros.svh]
// Assertion macros used by the envelope generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define ADSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form built on the macro above
`define ADSR_ASSERT_IMPL(label, ante, cons, msg) \
  `ADSR_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication form
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
  `ADSR_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/adsr_pkg.sv]
// Types, constants and the RC step function of the ADSR envelope generator.
`timescale 1ns / 1ps

package adsr_pkg;

  // Q1.16 level, 65536 is full scale
  typedef logic [16:0] level_t;
  typedef logic [15:0] coeff_t;

  localparam level_t FULL_SCALE    = 17'd65536;
  localparam level_t ATTACK_TARGET = 17'd66847;  // 1.02 of full scale
  localparam level_t SNAP_LSB      = 17'd7;

  // Register reset values
  localparam coeff_t ATTACK_RST  = 16'd655;
  localparam coeff_t DECAY_RST   = 16'd65;
  localparam level_t SUSTAIN_RST = 17'd32768;
  localparam coeff_t RELEASE_RST = 16'd65;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } adsr_stage_e;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } adsr_reg_e;

  typedef struct packed {
    coeff_t attack_coeff;
    coeff_t decay_coeff;
    level_t sustain_level;
    coeff_t release_coeff;
  } adsr_cfg_t;

  typedef struct packed {
    adsr_stage_e stage;
    level_t      level;
  } adsr_state_t;

  // One RC step: (coeff * span) >> 16, at least 1 LSB for a non-zero span, never past the target
  function automatic level_t rc_step(input coeff_t coeff, input level_t span);
    logic [32:0] prod;
    level_t      s;
    prod = {17'd0, coeff} * {16'd0, span};
    s    = prod[32:16];
    if ((s == '0) && (span != '0)) begin
      s = 17'd1;
    end
    if (s > span) begin
      s = span;
    end
    return s;
  endfunction

endpackage

[rtl/adsr_if.sv]
// Item channel interfaces of the envelope generator: gate in, envelope out.
`timescale 1ns / 1ps

interface adsr_in_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink   (input valid, input gate, output ready);
endinterface

interface adsr_out_if;
  logic               valid;
  logic               ready;
  adsr_pkg::level_t   env_out;
  adsr_pkg::level_t   inv_env_out;

  modport source (output valid, output env_out, output inv_env_out, input ready);
  modport sink   (input valid, input env_out, input inv_env_out, output ready);
endinterface

[rtl/adsr_step.sv]
// Next-state datapath: gate edge detect, one RC step and the stage transitions.
`timescale 1ns / 1ps

module adsr_step (
  input  adsr_pkg::adsr_state_t cur_i,
  input  logic                  gate_i,
  input  logic                  last_gate_i,
  input  adsr_pkg::adsr_cfg_t   cfg_i,
  output adsr_pkg::adsr_state_t nxt_o
);

  adsr_pkg::level_t    sus;
  adsr_pkg::adsr_stage_e stage_eff;
  adsr_pkg::coeff_t    coeff;
  adsr_pkg::level_t    span;
  adsr_pkg::level_t    step;
  adsr_pkg::level_t    stepped;
  adsr_pkg::level_t    sus_dist;
  logic                up;

  // Saturate sustain at full scale
  assign sus = (cfg_i.sustain_level > adsr_pkg::FULL_SCALE) ?
               adsr_pkg::FULL_SCALE : cfg_i.sustain_level;

  // Gate edges override the stored stage
  always_comb begin
    if (gate_i && !last_gate_i) begin
      stage_eff = adsr_pkg::ST_ATTACK;
    end else if (!gate_i && last_gate_i) begin
      stage_eff = adsr_pkg::ST_RELEASE;
    end else begin
      stage_eff = cur_i.stage;
    end
  end

  // Operand selection for the single shared multiply
  always_comb begin
    coeff = cfg_i.release_coeff;
    span  = cur_i.level;
    up    = 1'b0;
    unique case (stage_eff)
      adsr_pkg::ST_ATTACK: begin
        coeff = cfg_i.attack_coeff;
        span  = adsr_pkg::ATTACK_TARGET - cur_i.level;
        up    = 1'b1;
      end
      adsr_pkg::ST_DECAY: begin
        coeff = cfg_i.decay_coeff;
        up    = (sus >= cur_i.level);
        span  = up ? (sus - cur_i.level) : (cur_i.level - sus);
      end
      default: begin
        coeff = cfg_i.release_coeff;
        span  = cur_i.level;
        up    = 1'b0;
      end
    endcase
  end

  assign step     = adsr_pkg::rc_step(coeff, span);
  assign stepped  = up ? (cur_i.level + step) : (cur_i.level - step);
  assign sus_dist = (sus >= stepped) ? (sus - stepped) : (stepped - sus);

  // Clamp, snap and stage transitions
  always_comb begin
    nxt_o.stage = stage_eff;
    nxt_o.level = stepped;
    unique case (stage_eff)
      adsr_pkg::ST_ATTACK: begin
        if (stepped >= adsr_pkg::FULL_SCALE) begin
          nxt_o.level = adsr_pkg::FULL_SCALE;
          nxt_o.stage = adsr_pkg::ST_DECAY;
        end
      end
      adsr_pkg::ST_DECAY: begin
        if (sus_dist < adsr_pkg::SNAP_LSB) begin
          nxt_o.level = sus;
          nxt_o.stage = adsr_pkg::ST_SUSTAIN;
        end
      end
      adsr_pkg::ST_SUSTAIN: begin
        nxt_o.level = sus;
      end
      adsr_pkg::ST_RELEASE: begin
        if (stepped < adsr_pkg::SNAP_LSB) begin
          nxt_o.level = '0;
          nxt_o.stage = adsr_pkg::ST_IDLE;
        end
      end
      default: begin
        // idle, and any code without meaning, holds the level at zero
        nxt_o.level = '0;
      end
    endcase
  end

endmodule

[rtl/adsr_envelope_generator_unit.sv]
// Top level of the ADSR envelope generator: state, registers, APB port, handshakes.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------
//  in_i     | in  | valid / ready    | gate (1)
//  out_o    | out | valid / ready    | env_out (17), inv_env_out (17)
//  apb      | in  | psel/penable     | paddr (4), pwdata/prdata (32)
//
//  One item per cycle while the result register is free or being taken: the
//  next level is worked out from the state registers in a single pass through
//  one 16x17 multiply and lands in the result register, valid in the next cycle.
//  The input is ready whenever the result register is empty or being taken.
//  Reset clears the stage, level and gate history and loads register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adsr_envelope_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  adsr_in_if.sink     in_i,
  adsr_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  adsr_pkg::adsr_cfg_t   cfg_q;
  adsr_pkg::adsr_state_t state_q, state_d;
  logic                  last_gate_q;
  logic                  out_valid_q;
  adsr_pkg::level_t      env_q;
  adsr_pkg::level_t      inv_q;
  logic                  in_fire;
  logic                  cfg_wr;
  adsr_pkg::adsr_reg_e   reg_sel;

  assign reg_sel = adsr_pkg::adsr_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff  <= adsr_pkg::ATTACK_RST;
      cfg_q.decay_coeff   <= adsr_pkg::DECAY_RST;
      cfg_q.sustain_level <= adsr_pkg::SUSTAIN_RST;
      cfg_q.release_coeff <= adsr_pkg::RELEASE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        adsr_pkg::REG_ATTACK:  cfg_q.attack_coeff  <= pwdata[15:0];
        adsr_pkg::REG_DECAY:   cfg_q.decay_coeff   <= pwdata[15:0];
        adsr_pkg::REG_SUSTAIN: cfg_q.sustain_level <= pwdata[16:0];
        adsr_pkg::REG_RELEASE: cfg_q.release_coeff <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_sel)
      adsr_pkg::REG_ATTACK:  prdata = {16'd0, cfg_q.attack_coeff};
      adsr_pkg::REG_DECAY:   prdata = {16'd0, cfg_q.decay_coeff};
      adsr_pkg::REG_SUSTAIN: prdata = {15'd0, cfg_q.sustain_level};
      adsr_pkg::REG_RELEASE: prdata = {16'd0, cfg_q.release_coeff};
      default:               prdata = '0;
    endcase
  end

  // Handshake: accept while the result slot is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  adsr_step u_step (
    .cur_i       (state_q),
    .gate_i      (in_i.gate),
    .last_gate_i (last_gate_q),
    .cfg_i       (cfg_q),
    .nxt_o       (state_d)
  );

  // Envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage <= adsr_pkg::ST_IDLE;
      state_q.level <= '0;
      last_gate_q   <= 1'b0;
    end else if (in_fire) begin
      state_q     <= state_d;
      last_gate_q <= in_i.gate;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      env_q <= state_d.level;
      inv_q <= adsr_pkg::FULL_SCALE - state_d.level;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.env_out     = env_q;
  assign out_o.inv_env_out = inv_q;

  // Checks
  `ADSR_ASSERT_IMPL(a_inv_sum, out_valid_q, ({1'b0, env_q} + {1'b0, inv_q}) == 18'd65536, "envelope and inverse do not sum to full scale")
  `ADSR_ASSERT(a_level_range, state_q.level <= adsr_pkg::FULL_SCALE, "level above full scale")
  `ADSR_ASSERT_IMPL(a_idle_zero, state_q.stage == adsr_pkg::ST_IDLE, state_q.level == '0, "idle with non-zero level")
  `ADSR_ASSERT_NEXT(a_fire_valid, in_fire, out_valid_q, "accepted item produced no result")

endmodule

[test/adsr_envelope_generator_unit_tb.sv]
// Self-checking testbench for the ADSR envelope generator unit.
`timescale 1ns / 1ps

module adsr_envelope_generator_unit_tb;

  // One envelope result: level and its complement
  typedef struct packed {
    adsr_pkg::level_t env;
    adsr_pkg::level_t inv;
  } env_pair_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  adsr_in_if  in_ch ();
  adsr_out_if out_ch ();

  adsr_envelope_generator_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and the envelope state
  adsr_pkg::coeff_t      cfg_attack;
  adsr_pkg::coeff_t      cfg_decay;
  adsr_pkg::level_t      cfg_sustain;
  adsr_pkg::coeff_t      cfg_release;
  adsr_pkg::adsr_stage_e env_stage;
  adsr_pkg::level_t      env_level;
  logic                  env_last_gate;

  env_pair_t   pending_env_q[$];

  int          fail_count;
  int          items_sent;
  int          results_checked;
  int          reg_writes;
  int          phrases_played;
  bit          no_idle;
  bit          hold_request;

  localparam int HOLD_CYCLES = 150;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("adsr_envelope_generator_unit_tb: FAIL");
    $finish;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // RC step toward a target, at least 1 LSB for a non-zero span, never overshooting
  function automatic adsr_pkg::level_t rc_move(input adsr_pkg::coeff_t k,
                                               input adsr_pkg::level_t span);
    longint unsigned  prod;
    adsr_pkg::level_t s;
    prod = (longint'(k) * longint'(span)) >> 16;
    s    = adsr_pkg::level_t'(prod);
    if (s == 17'd0 && span != 17'd0) s = 17'd1;
    if (s > span) s = span;
    return s;
  endfunction

  // Advance the predicted envelope by one gate sample
  function automatic env_pair_t advance_envelope(input logic g);
    adsr_pkg::level_t sus;
    adsr_pkg::level_t d;
    env_pair_t        r;
    sus = (cfg_sustain > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : cfg_sustain;
    if (g && !env_last_gate) env_stage = adsr_pkg::ST_ATTACK;
    if (!g && env_last_gate) env_stage = adsr_pkg::ST_RELEASE;
    env_last_gate = g;
    case (env_stage)
      adsr_pkg::ST_ATTACK: begin
        env_level = env_level + rc_move(cfg_attack, adsr_pkg::ATTACK_TARGET - env_level);
        if (env_level >= adsr_pkg::FULL_SCALE) begin
          env_level = adsr_pkg::FULL_SCALE;
          env_stage = adsr_pkg::ST_DECAY;
        end
      end
      adsr_pkg::ST_DECAY: begin
        if (sus >= env_level) env_level = env_level + rc_move(cfg_decay, sus - env_level);
        else env_level = env_level - rc_move(cfg_decay, env_level - sus);
        d = (sus >= env_level) ? sus - env_level : env_level - sus;
        if (d < adsr_pkg::SNAP_LSB) begin
          env_level = sus;
          env_stage = adsr_pkg::ST_SUSTAIN;
        end
      end
      adsr_pkg::ST_SUSTAIN: env_level = sus;
      adsr_pkg::ST_RELEASE: begin
        env_level = env_level - rc_move(cfg_release, env_level);
        if (env_level < adsr_pkg::SNAP_LSB) begin
          env_level = 17'd0;
          env_stage = adsr_pkg::ST_IDLE;
        end
      end
      default: env_level = 17'd0;
    endcase
    r.env = env_level;
    r.inv = adsr_pkg::FULL_SCALE - env_level;
    return r;
  endfunction

  // Offer one gate item and log its expected envelope once accepted
  task automatic send_gate(input logic g);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.gate  <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.gate  <= g;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_env_q.push_back(advance_envelope(g));
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_env_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(input adsr_pkg::adsr_reg_e idx, input logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      adsr_pkg::REG_ATTACK:  cfg_attack  = data[15:0];
      adsr_pkg::REG_DECAY:   cfg_decay   = data[15:0];
      adsr_pkg::REG_SUSTAIN: cfg_sustain = data[16:0];
      default:               cfg_release = data[15:0];
    endcase
    want = (idx == adsr_pkg::REG_SUSTAIN) ? {15'd0, data[16:0]} : {16'd0, data[15:0]};
    reg_writes++;
    // read-back phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $error("prdata reg %s: expected %0d, got %0d", idx.name(), want, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] atk, input logic [31:0] dcy,
                           input logic [31:0] sus, input logic [31:0] rel);
    write_reg(adsr_pkg::REG_ATTACK, atk);
    write_reg(adsr_pkg::REG_DECAY, dcy);
    write_reg(adsr_pkg::REG_SUSTAIN, sus);
    write_reg(adsr_pkg::REG_RELEASE, rel);
  endtask

  function automatic logic [31:0] pick_coeff();
    int r;
    logic [31:0] noise;
    noise = $urandom;
    r = $urandom_range(0, 99);
    if (r < 8) return {noise[31:16], 16'd0};
    if (r < 16) return {noise[31:16], 16'hFFFF};
    if (r < 22) return {noise[31:16], 16'd1};
    return {noise[31:16], 16'($urandom_range(1, 65535) >> $urandom_range(0, 10))};
  endfunction

  function automatic logic [31:0] pick_sustain();
    int r;
    logic [31:0] noise;
    noise = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10) return {noise[31:17], adsr_pkg::FULL_SCALE};
    if (r < 18) return {noise[31:17], 17'd0};
    if (r < 26) return {noise[31:17], 17'($urandom_range(65537, 131071))};
    return {noise[31:17], 17'($urandom_range(0, 65536))};
  endfunction

  // Sends a list of gate levels
  task automatic send_pattern(input logic g[]);
    foreach (g[i]) send_gate(g[i]);
  endtask

  // Idle after reset: level stays at zero with reset registers
  task automatic test_reset_idle();
    send_pattern('{1'b0, 1'b0, 1'b0});
    settle();
  endtask

  // Steepest coefficients: attack clamps, decay snaps, release snaps to idle
  task automatic test_fast_envelope();
    write_all(32'h0000_FFFF, 32'hA5A5_FFFF, {15'h1234, adsr_pkg::FULL_SCALE},
              32'hFFFF_FFFF);
    send_pattern('{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
    settle();
  endtask

  // Sustain written above full scale must behave as full scale
  task automatic test_sustain_above_full();
    write_all(32'h0000_8000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_C000);
    send_pattern('{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    settle();
  endtask

  // Zero coefficients still step by 1 LSB; retrigger from attack and release
  task automatic test_zero_coeff_retrigger();
    write_all(32'hFFFF_0000, 32'h5A5A_0000, 32'hFFFE_0000, 32'hFFFF_0000);
    send_pattern('{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0});
    settle();
  endtask

  // Note phrases: held then released, random lengths, some broken short notes
  task automatic play_phrases(input int n_items);
    int   sent;
    int   len;
    int   r;
    logic g;
    sent = 0;
    g    = 1'b1;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = $urandom_range(1, 2);
      else if (r < 85) len = $urandom_range(3, 40);
      else len = $urandom_range(41, 150);
      if (len > n_items - sent) len = n_items - sent;
      repeat (len) begin
        // occasional noise sample inside a note
        if ($urandom_range(0, 99) < 4) send_gate(1'($urandom));
        else send_gate(g);
        sent++;
      end
      g = ~g;
      phrases_played++;
    end
  endtask

  // Random register settings, each followed by a burst of phrases
  task automatic test_random_phrases();
    for (int p = 0; p < 9; p++) begin
      settle();
      write_all(pick_coeff(), pick_coeff(), pick_sustain(), pick_coeff());
      no_idle = (p % 4 == 3);
      play_phrases(140);
    end
    no_idle = 1'b0;
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    settle();
    hold_request = 1'b1;
    // the receiver clears the request as its hold begins
    wait (hold_request == 1'b0);
    no_idle      = 1'b1;
    play_phrases(40);
    no_idle      = 1'b0;
  endtask

  // Result receiver: random stalls plus one long hold when asked
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      int stall;
      int run;
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk_i);
    end
  end

  // Result checker against the oldest outstanding prediction
  always @(posedge clk_i) begin
    env_pair_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_env_q.size() == 0) begin
        $error("result item with nothing outstanding: env_out %0d", out_ch.env_out);
        fail_count++;
      end else begin
        want = pending_env_q.pop_front();
        results_checked++;
        if (out_ch.env_out !== want.env) begin
          $error("env_out: expected %0d, got %0d", want.env, out_ch.env_out);
          fail_count++;
        end
        if (out_ch.inv_env_out !== want.inv) begin
          $error("inv_env_out: expected %0d, got %0d", want.inv, out_ch.inv_env_out);
          fail_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    fail_count      = 0;
    items_sent      = 0;
    results_checked = 0;
    reg_writes      = 0;
    phrases_played  = 0;
    no_idle         = 1'b0;
    hold_request    = 1'b0;
    cfg_attack      = adsr_pkg::ATTACK_RST;
    cfg_decay       = adsr_pkg::DECAY_RST;
    cfg_sustain     = adsr_pkg::SUSTAIN_RST;
    cfg_release     = adsr_pkg::RELEASE_RST;
    env_stage       = adsr_pkg::ST_IDLE;
    env_level       = 17'd0;
    env_last_gate   = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.gate      = 1'b0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = 4'd0;
    pwdata          = 32'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_idle();
    test_fast_envelope();
    test_sustain_above_full();
    test_zero_coeff_retrigger();
    test_random_phrases();
    test_backpressure();
    settle();
    repeat (5) @(posedge clk_i);

    if (pending_env_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_env_q.size());
      fail_count++;
    end
    $display("Sent %0d gate items in %0d note phrases over %0d register writes,",
             items_sent, phrases_played, reg_writes);
    $display("checked %0d envelope results, including one long output hold-off.",
             results_checked);
    if (fail_count == 0) begin
      $display("adsr_envelope_generator_unit_tb: PASS");
    end else begin
      $display("adsr_envelope_generator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_if.sv
rtl/adsr_step.sv
rtl/adsr_envelope_generator_unit.sv
test/adsr_envelope_generator_unit_tb.sv
